@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion checked while reset is released.
`define PWA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define PWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/pwa_pkg.sv @@
// ----------------------------------------------------------------------------
// pwa_pkg
// Types and constants of the per-position Welford accumulator.
// ----------------------------------------------------------------------------
package pwa_pkg;

  // Statistics table geometry (power of two, at most 4096 entries).
  localparam int POSITIONS = 4096;
  localparam int IDX_W     = $clog2(POSITIONS);

  // Field widths.
  localparam int CNT_W  = 16;
  localparam int MEAN_W = 24;
  localparam int SQ_W   = 56;
  localparam int STD_W  = 16;
  localparam int SMP_W  = 16;
  localparam int ENTRY_W = CNT_W + MEAN_W + SQ_W;

  // Shared unit geometry.
  localparam int REM_W  = 27;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] MEAN_DIV_STEPS = STEP_W'(MEAN_W);
  localparam logic [STEP_W-1:0] VAR_DIV_STEPS  = STEP_W'(SQ_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS     = STEP_W'(24);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SQ_W-1:0]  SQ_MAX  = '1;

  // Configuration register indexes.
  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;
  localparam logic [15:0] HIGH_LIMIT_RST = 16'd64000;

  // Input opcodes.
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ACCUMULATED = 2'd0;
  localparam logic [1:0] ST_REJECTED    = 2'd1;
  localparam logic [1:0] ST_COUNT_FULL  = 2'd2;
  localparam logic [1:0] ST_READ        = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CHECK, S_DIVM, S_MUL, S_ACC, S_WR,
    S_STD, S_DIVV, S_SQRT, S_DONE
  } pwa_state_t;

  // Request to the shared divide / square-root unit.
  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [STEP_W-1:0] steps;
  } pwa_req_t;

endpackage

@@ hw/rtl/pwa_ram.sv @@
// ----------------------------------------------------------------------------
// pwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/pwa_divsqrt.sv @@
// ----------------------------------------------------------------------------
// pwa_divsqrt
// Shared radix-2 divider and digit-by-digit square root, one step per cycle.
// ----------------------------------------------------------------------------
module pwa_divsqrt
  import pwa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  pwa_req_t         req,
  input  logic [SQ_W-1:0]  num,
  input  logic [CNT_W-1:0] den,
  output logic             done,
  output logic [SQ_W-1:0]  quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              sqrt_r;
  logic [STEP_W-1:0] cnt_r;
  logic [SQ_W-1:0]   num_r;
  logic [SQ_W-1:0]   q_r;
  logic [REM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // One compare-subtract step: divisor for division, 4r+1 for square root.
  always_comb begin
    if (sqrt_r) begin
      rem_sh = {rem_r[REM_W-3:0], num_r[SQ_W-1 -: 2]};
      trial  = {q_r[REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[REM_W-2:0], num_r[SQ_W-1]};
      trial  = REM_W'(den_r);
    end
    ge = (rem_sh >= trial);
  end

  // Control flags.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == STEP_W'(1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath: load on start, then shift one digit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      sqrt_r <= req.is_sqrt;
      cnt_r  <= req.steps;
      num_r  <= num;
      den_r  <= den;
      q_r    <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - STEP_W'(1);
      num_r <= sqrt_r ? {num_r[SQ_W-3:0], 2'b00} : {num_r[SQ_W-2:0], 1'b0};
      q_r   <= {q_r[SQ_W-2:0], ge};
      rem_r <= ge ? rem_sh - trial : rem_sh;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ hw/rtl/per_position_welford_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// per_position_welford_accumulator_core
// Per-position running count, mean and standard deviation (Welford update).
// ----------------------------------------------------------------------------
// Input stream: in_tuser is the opcode (accumulate or read), in_tdata holds
// the position and a Q8.8 sample. Every transaction gives exactly one result
// transaction: out_tuser is the status, out_tdata carries count, Q8.16 mean
// and Q8.8 standard deviation of the entry after the update.
// One item is processed at a time through a single shared divide/sqrt unit
// that resolves one bit (division) or one root digit (sqrt) per cycle. An
// accumulate runs the 24-step mean division; every item whose count is two
// or more then runs the 56-step variance division and the 24-digit root. The
// next item can be taken in the cycle after the result is loaded. After reset
// the table is cleared one entry per cycle, all 4096 entries; in_tready stays
// low meanwhile, configuration writes are taken.
// A stalled result sits in the output register; the next item is accepted
// while it waits, and that item's result holds in the final state.
// ----------------------------------------------------------------------------
module per_position_welford_accumulator_core
  import pwa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // position[11:0], sample[27:12], zero pad
  input  logic        in_tuser,   // opcode
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // sample_count[15:0], running_mean[39:16],
                                  // std_dev[55:40]
  output logic [1:0]  out_tuser   // status
);

  pwa_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  clr_r;
  logic              op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SMP_W-1:0]  smp_r;
  logic [1:0]        st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MEAN_W-1:0] mean_r;
  logic [SQ_W-1:0]   sq_r;
  logic [MEAN_W-1:0] a1_r;
  logic              neg_r;
  logic [39:0]       prod_r;
  logic [STD_W-1:0]  std_r;
  logic [15:0]       low_r, high_r;
  logic              out_valid_r;
  logic [55:0]       out_data_r;
  logic [1:0]        out_user_r;

  // RAM and shared unit connections.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  pwa_req_t          req;
  logic [SQ_W-1:0]   unit_num;
  logic [CNT_W-1:0]  unit_den;
  logic              unit_done;
  logic [SQ_W-1:0]   unit_quo;

  // Fields of the entry just read.
  logic [CNT_W-1:0]  rd_cnt;
  logic [MEAN_W-1:0] rd_mean;
  logic [SQ_W-1:0]   rd_sq;
  logic [MEAN_W-1:0] xs;
  logic              in_range;
  logic [1:0]        st_c;
  logic [MEAN_W-1:0] a1_c, a2_c;
  logic [SQ_W:0]     sq_sum;
  logic              out_load;

  assign rd_cnt  = ram_rdata[CNT_W-1:0];
  assign rd_mean = ram_rdata[CNT_W +: MEAN_W];
  assign rd_sq   = ram_rdata[CNT_W+MEAN_W +: SQ_W];
  assign xs      = {smp_r, 8'h00};

  // Status decision: opcode, then the range window, then the count limit.
  always_comb begin
    in_range = (smp_r > low_r) && (smp_r < high_r);
    if (op_r == OP_READ) begin
      st_c = ST_READ;
    end else if (!in_range) begin
      st_c = ST_REJECTED;
    end else if (rd_cnt == CNT_MAX) begin
      st_c = ST_COUNT_FULL;
    end else begin
      st_c = ST_ACCUMULATED;
    end
    a1_c = (xs >= rd_mean) ? xs - rd_mean : rd_mean - xs;
    a2_c = (xs >= mean_r) ? xs - mean_r : mean_r - xs;
    sq_sum = {1'b0, sq_r} + (SQ_W+1)'(prod_r);
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == IDX_W'(POSITIONS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_tvalid) state_nxt = S_RD;
      S_RD:    state_nxt = S_CHECK;
      S_CHECK: state_nxt = (st_c == ST_ACCUMULATED) ? S_DIVM : S_STD;
      S_DIVM:  if (unit_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = S_WR;
      S_WR:    state_nxt = S_STD;
      S_STD:   state_nxt = (cnt_r < CNT_W'(2)) ? S_DONE : S_DIVV;
      S_DIVV:  if (unit_done) state_nxt = S_SQRT;
      S_SQRT:  if (unit_done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, RAM write and unit requests.
  always_comb begin
    in_tready   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = {sq_r, mean_r, cnt_r};
    req.start   = 1'b0;
    req.is_sqrt = 1'b0;
    req.steps   = MEAN_DIV_STEPS;
    unit_num    = {a1_c, 32'h0};
    unit_den    = rd_cnt + CNT_W'(1);
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_IDLE:  in_tready = 1'b1;
      S_CHECK: req.start = (st_c == ST_ACCUMULATED);
      S_WR:    ram_we = 1'b1;
      S_STD: begin
        req.start = (cnt_r >= CNT_W'(2));
        req.steps = VAR_DIV_STEPS;
        unit_num  = sq_r;
        unit_den  = cnt_r - CNT_W'(1);
      end
      S_DIVV: begin
        req.start   = unit_done;
        req.is_sqrt = 1'b1;
        req.steps   = SQRT_STEPS;
        unit_num    = {unit_quo[SQ_W-1:8], 8'h00};
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      low_r       <= '0;
      high_r      <= HIGH_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_LOW_LIMIT) low_r <= cfg_wdata;
        if (cfg_addr == CFG_HIGH_LIMIT) high_r <= cfg_wdata;
      end
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r  <= in_tuser;
        idx_r <= in_tdata[IDX_W-1:0];
        smp_r <= in_tdata[12 +: SMP_W];
      end
      S_CHECK: begin
        st_r   <= st_c;
        cnt_r  <= rd_cnt;
        mean_r <= rd_mean;
        sq_r   <= rd_sq;
        a1_r   <= a1_c;
        neg_r  <= (xs < rd_mean);
      end
      S_DIVM: begin
        if (unit_done) begin
          mean_r <= neg_r ? mean_r - unit_quo[MEAN_W-1:0]
                          : mean_r + unit_quo[MEAN_W-1:0];
        end
      end
      S_MUL: begin
        prod_r <= 40'((48'(a1_r) * 48'(a2_c)) >> 8);
      end
      S_ACC: begin
        sq_r  <= sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
      end
      S_STD: begin
        std_r <= '0;
      end
      S_SQRT: begin
        if (unit_done) begin
          std_r <= (unit_quo[23:16] != 8'h00) ? '1 : unit_quo[STD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {std_r, mean_r, cnt_r};
      out_user_r <= st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  pwa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(POSITIONS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  pwa_divsqrt u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .num  (unit_num),
    .den  (unit_den),
    .done (unit_done),
    .quo  (unit_quo)
  );

endmodule

@@ hw/rtl/pwa_checker.sv @@
// ----------------------------------------------------------------------------
// pwa_checker
// Port-level checks of the per-position Welford accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pwa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A result that is not taken stays unchanged.
  `PWA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // Only one item is in work: an accepted item drops ready in the next cycle.
  `PWA_ASSERT(a_one_item, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "ready held after accept")

  // No result follows reset directly.
  `PWA_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // Fewer than two samples report a zero deviation.
  `PWA_ASSERT(a_std_zero, clk, rst_n, out_tvalid && out_tdata[15:1] == 15'h0 |-> out_tdata[55:40] == 16'h0, "nonzero deviation below two samples")

endmodule

bind per_position_welford_accumulator_core pwa_checker u_chk (.*);
